// ----- design/pac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants
// Request codes, result codes, item structs and the control interface types
// of the pretrigger audio capture controller.
// ----------------------------------------------------------------------------
package pac_pkg;

	typedef enum logic [2:0] {
		REQ_SAMPLE, REQ_ARM, REQ_START, REQ_FINISH,
		REQ_CANCEL, REQ_DISCARD, REQ_TICK, REQ_READ
	} req_t;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ARMED = 2'd1;
	localparam logic [1:0] MODE_REC   = 2'd2;
	localparam logic [1:0] MODE_CLIP  = 2'd3;

	localparam logic [1:0] STOP_NONE   = 2'd0;
	localparam logic [1:0] STOP_FINISH = 2'd1;
	localparam logic [1:0] STOP_MAX    = 2'd2;
	localparam logic [1:0] STOP_CANCEL = 2'd3;

	localparam int CFG_W     = 19;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREROLL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXCLIP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd2;

	localparam logic [14:0] RST_PREROLL = 15'd16000;
	localparam logic [18:0] RST_MAXCLIP = 19'd160000;
	localparam logic [15:0] RST_DELAY   = 16'd220;

	localparam logic [6:0]  PCT_MAX   = 7'd100;
	localparam logic [23:0] PCT_MUL   = 24'd100;
	localparam int          PCT_SHIFT = 15;

	typedef struct packed {
		req_t               req_type;
		logic signed [15:0] pcm_sample;
		logic               chunk_end;
		logic               with_preroll;
		logic [17:0]        read_index;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic [1:0]         mode_state;
		logic               preview_on;
		logic               clip_present;
		logic [18:0]        recorded_count;
		logic [6:0]         level_percent;
		logic [1:0]         stop_cause;
		logic signed [15:0] read_sample;
		logic               read_valid;
	} out_item_t;

	typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_MUL, ST_LOAD} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic mul;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic div_needed;
		logic out_free;
	} sts_t;

endpackage

// ----- design/pretrigger_audio_capture_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pretrigger_audio_capture_controller: audio recorder with preroll ring
// Every request item (sample, arm, start, finish, cancel, discard, tick,
// read) yields one result item carrying mode, flags, counts and read data.
//
// Items enter on in_valid/in_stall and leave on out_valid/out_stall; each
// side moves an item at an edge where valid is high and stall low.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Each item passes an execute
// and a load state; a sample closing a chunk also runs the bit-serial level
// divider and a level multiply. Input stalls until the load, which can take
// the next item. Reads take the clip or preroll RAM's registered read port.
// A finished result waits in the output register while the next item is
// accepted; if out_stall holds, that next result waits in the sequencer
// and input is stalled. Reset clears all flags and counters and loads the
// register defaults; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module pretrigger_audio_capture_controller import pac_pkg::*; #(
	parameter int PREROLL_DEPTH = 16384,
	parameter int CLIP_DEPTH    = 262144,
	parameter int MAX_CHUNK     = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	localparam int DIV_STEPS = 16 + $clog2(MAX_CHUNK);

	cmd_t cmd;
	sts_t sts;

	pac_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pac_dp #(
		.PREROLL_DEPTH (PREROLL_DEPTH),
		.CLIP_DEPTH    (CLIP_DEPTH),
		.MAX_CHUNK     (MAX_CHUNK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- design/pac_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/pac_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_ctrl: sequencing state machine
// Accepts items, steps the level divider and loads the result register.
// ----------------------------------------------------------------------------
module pac_ctrl import pac_pkg::*; #(
	parameter int DIV_STEPS = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	ctrl_state_t state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = sts.div_needed ? ST_DIV : ST_LOAD;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					in_stall  = 1'b0;
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_nxt   = ST_EXEC;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (cnt_q == '0)) else $error("divider count stray");
	a_exec_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC)) else $error("capture not executed");
	a_mul_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> (state_q == ST_LOAD)) else $error("level not followed by load");

endmodule

// ----- design/pac_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_dp: capture datapath
// Mode flags, preroll ring, clip store, level divider and result register.
// ----------------------------------------------------------------------------
module pac_dp import pac_pkg::*; #(
	parameter int PREROLL_DEPTH = 16384,
	parameter int CLIP_DEPTH    = 262144,
	parameter int MAX_CHUNK     = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  in_item_t             in_item,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	localparam int PA_W  = $clog2(PREROLL_DEPTH);
	localparam int PC_W  = $clog2(PREROLL_DEPTH + 1);
	localparam int CA_W  = $clog2(CLIP_DEPTH);
	localparam int CNT_W = $clog2(CLIP_DEPTH + 1);
	localparam int LEN_W = $clog2(MAX_CHUNK + 1);
	localparam int SUM_W = 16 + $clog2(MAX_CHUNK);

	logic [14:0] cfg_pre_q;
	logic [18:0] cfg_max_q;
	logic [15:0] cfg_dly_q;
	in_item_t    item_q;

	logic armed_q, rec_q, prev_q, clip_q, trun_q, status_q, rvalid_q, src_q;
	logic [1:0]       stop_q;
	logic [6:0]       level_q;
	logic [SUM_W-1:0] sum_q, quo_q;
	logic [LEN_W-1:0] len_q, dvs_q, rem_q;
	logic [PA_W-1:0]  wpos_q, pstart_q;
	logic [PC_W-1:0]  fill_q, plen_q, cap_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      timer_q;

	logic [PC_W-1:0]  cap_new, wpos_inc, plen_new;
	logic [PA_W-1:0]  wpos_n, pstart_new, pre_raddr;
	logic [CNT_W-1:0] lim, count_n;
	logic [16:0]      mag;
	logic [SUM_W-1:0] sum_n;
	logic [LEN_W-1:0] len_n, rem_next;
	logic [LEN_W:0]   rem_sh;
	logic [PC_W:0]    wp_plus, pa;
	logic             last, active, do_sample, pre_we, clip_we, max_stop;
	logic             hit, in_pre, do_read, ge, out_free;
	logic [23:0]      prod;
	logic [8:0]       pct;
	logic [6:0]       level_new;
	logic [15:0]      pre_rd, clip_rd;

	always_comb begin
		if (cfg_pre_q == '0) begin
			cap_new = PC_W'(1);
		end else if (32'(cfg_pre_q) > PREROLL_DEPTH) begin
			cap_new = PC_W'(PREROLL_DEPTH);
		end else begin
			cap_new = PC_W'(cfg_pre_q);
		end
		lim = (32'(cfg_max_q) > CLIP_DEPTH) ? CNT_W'(CLIP_DEPTH) : CNT_W'(cfg_max_q);

		mag    = item_q.pcm_sample[15] ? (17'({1'b0, ~item_q.pcm_sample}) + 17'd1)
		                               : 17'({1'b0, item_q.pcm_sample});
		sum_n  = sum_q + SUM_W'(mag);
		len_n  = len_q + 1'b1;
		last   = item_q.chunk_end || (32'(len_n) >= MAX_CHUNK);
		active = armed_q || rec_q;

		do_sample = cmd.exec && (item_q.req_type == REQ_SAMPLE) && active;
		pre_we    = do_sample && armed_q && !rec_q;
		clip_we   = do_sample && rec_q && (32'(count_q) < 32'(lim));
		count_n   = count_q + CNT_W'(clip_we);
		max_stop  = do_sample && last && rec_q && (32'(count_n) >= 32'(lim));
		wpos_inc  = PC_W'(wpos_q) + 1'b1;
		wpos_n    = (wpos_inc >= cap_q) ? '0 : PA_W'(wpos_inc);

		wp_plus    = (PC_W+1)'(wpos_q) + (PC_W+1)'(cap_q) - (PC_W+1)'(fill_q);
		pstart_new = (wp_plus >= (PC_W+1)'(cap_q)) ? PA_W'(wp_plus - (PC_W+1)'(cap_q))
		                                           : PA_W'(wp_plus);
		plen_new   = (32'(fill_q) < 32'(lim)) ? fill_q : PC_W'(lim);

		hit       = clip_q && (32'(item_q.read_index) < 32'(count_q));
		in_pre    = 32'(item_q.read_index) < 32'(plen_q);
		pa        = (PC_W+1)'(pstart_q) + (PC_W+1)'(item_q.read_index);
		pre_raddr = (pa >= (PC_W+1)'(cap_q)) ? PA_W'(pa - (PC_W+1)'(cap_q)) : PA_W'(pa);
		do_read   = cmd.exec && (item_q.req_type == REQ_READ) && hit;

		rem_sh   = {rem_q, quo_q[SUM_W-1]};
		ge       = rem_sh >= {1'b0, dvs_q};
		rem_next = ge ? LEN_W'(rem_sh - {1'b0, dvs_q}) : LEN_W'(rem_sh);

		prod      = 24'(quo_q[16:0]) * PCT_MUL;
		pct       = prod[PCT_SHIFT +: 9];
		level_new = (pct > 9'(PCT_MAX)) ? PCT_MAX : 7'(pct);

		out_free       = !out_valid || !out_stall;
		sts.out_free   = out_free;
		sts.div_needed = do_sample && last;
	end

	pac_ram #(.WIDTH(16), .DEPTH(PREROLL_DEPTH)) u_pre_ram (
		.clk   (clk),
		.we    (pre_we),
		.waddr (wpos_q),
		.wdata (item_q.pcm_sample),
		.re    (do_read && in_pre),
		.raddr (pre_raddr),
		.rdata (pre_rd)
	);

	pac_ram #(.WIDTH(16), .DEPTH(CLIP_DEPTH)) u_clip_ram (
		.clk   (clk),
		.we    (clip_we),
		.waddr (CA_W'(count_q)),
		.wdata (item_q.pcm_sample),
		.re    (do_read && !in_pre),
		.raddr (CA_W'(item_q.read_index)),
		.rdata (clip_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pre_q <= RST_PREROLL;
			cfg_max_q <= RST_MAXCLIP;
			cfg_dly_q <= RST_DELAY;
			armed_q   <= 1'b0;
			rec_q     <= 1'b0;
			prev_q    <= 1'b0;
			clip_q    <= 1'b0;
			trun_q    <= 1'b0;
			status_q  <= 1'b0;
			rvalid_q  <= 1'b0;
			src_q     <= 1'b0;
			stop_q    <= STOP_NONE;
			level_q   <= '0;
			sum_q     <= '0;
			len_q     <= '0;
			wpos_q    <= '0;
			fill_q    <= '0;
			pstart_q  <= '0;
			plen_q    <= '0;
			count_q   <= '0;
			timer_q   <= '0;
			cap_q     <= PC_W'(PREROLL_DEPTH);
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PREROLL: cfg_pre_q <= cfg_data[14:0];
					CFG_MAXCLIP: cfg_max_q <= cfg_data[18:0];
					CFG_DELAY:   cfg_dly_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				status_q <= 1'b0;
				rvalid_q <= 1'b0;
				case (item_q.req_type)
					REQ_SAMPLE: begin
						if (active) begin
							if (pre_we) begin
								wpos_q <= wpos_n;
								if (fill_q < cap_q) begin
									fill_q <= fill_q + 1'b1;
								end
							end
							count_q <= count_n;
							if (last) begin
								sum_q <= '0;
								len_q <= '0;
							end else begin
								sum_q <= sum_n;
								len_q <= len_n;
							end
							if (max_stop) begin
								rec_q   <= 1'b0;
								armed_q <= 1'b0;
								stop_q  <= STOP_MAX;
								clip_q  <= (count_n != '0);
							end
						end
					end
					REQ_ARM: begin
						armed_q  <= 1'b1;
						rec_q    <= 1'b0;
						prev_q   <= 1'b0;
						stop_q   <= STOP_NONE;
						level_q  <= '0;
						sum_q    <= '0;
						len_q    <= '0;
						cap_q    <= cap_new;
						wpos_q   <= '0;
						fill_q   <= '0;
						pstart_q <= '0;
						plen_q   <= '0;
						count_q  <= '0;
						clip_q   <= 1'b0;
						timer_q  <= cfg_dly_q;
						trun_q   <= 1'b1;
					end
					REQ_START: begin
						if (!armed_q || rec_q) begin
							status_q <= 1'b1;
						end else begin
							if (item_q.with_preroll) begin
								pstart_q <= pstart_new;
								plen_q   <= plen_new;
								count_q  <= CNT_W'(plen_new);
							end else begin
								plen_q  <= '0;
								count_q <= '0;
							end
							rec_q  <= 1'b1;
							prev_q <= 1'b0;
							stop_q <= STOP_NONE;
							trun_q <= 1'b0;
						end
					end
					REQ_FINISH: begin
						if (!active) begin
							status_q <= 1'b1;
						end else begin
							if (rec_q) begin
								clip_q <= (count_q != '0);
							end
							rec_q   <= 1'b0;
							armed_q <= 1'b0;
							prev_q  <= 1'b0;
							stop_q  <= STOP_FINISH;
							trun_q  <= 1'b0;
							sum_q   <= '0;
							len_q   <= '0;
						end
					end
					REQ_CANCEL: begin
						armed_q  <= 1'b0;
						rec_q    <= 1'b0;
						prev_q   <= 1'b0;
						stop_q   <= STOP_CANCEL;
						wpos_q   <= '0;
						fill_q   <= '0;
						pstart_q <= '0;
						plen_q   <= '0;
						count_q  <= '0;
						clip_q   <= 1'b0;
						trun_q   <= 1'b0;
						sum_q    <= '0;
						len_q    <= '0;
					end
					REQ_DISCARD: begin
						clip_q <= 1'b0;
						prev_q <= 1'b0;
						if (!active) begin
							stop_q <= STOP_NONE;
						end
						trun_q <= 1'b0;
					end
					REQ_TICK: begin
						if (trun_q) begin
							if (timer_q <= 16'd1) begin
								trun_q  <= 1'b0;
								timer_q <= '0;
								if (armed_q && !rec_q) begin
									prev_q <= 1'b1;
								end
							end else begin
								timer_q <= timer_q - 1'b1;
							end
						end
					end
					REQ_READ: begin
						rvalid_q <= hit;
						src_q    <= !in_pre;
					end
					default: ;
				endcase
			end
			if (cmd.mul) begin
				level_q <= level_new;
			end
			if (cmd.load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (sts.div_needed) begin
			quo_q <= sum_n;
			rem_q <= '0;
			dvs_q <= len_n;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
		if (cmd.load) begin
			out_item.status         <= status_q;
			out_item.mode_state     <= rec_q ? MODE_REC : armed_q ? MODE_ARMED :
			                           clip_q ? MODE_CLIP : MODE_IDLE;
			out_item.preview_on     <= prev_q;
			out_item.clip_present   <= clip_q;
			out_item.recorded_count <= 19'(count_q);
			out_item.level_percent  <= level_q;
			out_item.stop_cause     <= stop_q;
			out_item.read_sample    <= rvalid_q ? (src_q ? clip_rd : pre_rd) : 16'sd0;
			out_item.read_valid     <= rvalid_q;
		end
	end

	a_rec_armed: assert property (@(posedge clk) disable iff (!arst_n)
		rec_q |-> armed_q) else $error("recording without armed");
	a_preview: assert property (@(posedge clk) disable iff (!arst_n)
		prev_q |-> (armed_q && !rec_q)) else $error("preview outside armed");
	a_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= cap_q) && (PC_W'(wpos_q) < cap_q)) else $error("ring pointers out of range");
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(plen_q) <= 32'(count_q)) || !rec_q) else $error("prefix exceeds clip");

endmodule

// ----- test/pac_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_checker: result checker for the pretrigger audio capture controller
// Watches the register port and both item channels, keeps its own copy of
// the recorder state (preroll ring, clip store, flags, level and preview
// timer), works out the result of every accepted request and compares each
// delivered result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module pac_checker import pac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_item,
	output int                   errors,
	output int                   pending,
	output int                   results_seen
);

	localparam int RING_D = 16384;
	localparam int CLIP_D = 262144;
	localparam int CHUNK_D = 4096;

	out_item_t outstanding[$];

	logic [14:0] reg_preroll;
	logic [18:0] reg_maxclip;
	logic [15:0] reg_delay;

	bit armed, recording, preview, clip_held, timer_on;
	logic [1:0] stop;
	logic [6:0] level;
	longint chunk_sum;
	int unsigned chunk_len;
	logic [15:0] ring_mem [RING_D];
	logic [15:0] clip_mem [CLIP_D];
	int unsigned wr_pos, fill, pfx_start, pfx_len, clip_cnt, timer, cap;

	function automatic int unsigned clip_limit();
		return (reg_maxclip > CLIP_D) ? CLIP_D : reg_maxclip;
	endfunction

	function automatic int unsigned ring_capacity();
		if (reg_preroll < 1) return 1;
		if (reg_preroll > RING_D) return RING_D;
		return reg_preroll;
	endfunction

	task automatic reset_recorder();
		reg_preroll = RST_PREROLL;
		reg_maxclip = RST_MAXCLIP;
		reg_delay   = RST_DELAY;
		armed = 0; recording = 0; preview = 0; clip_held = 0; timer_on = 0;
		stop = STOP_NONE;
		level = 0;
		chunk_sum = 0; chunk_len = 0;
		wr_pos = 0; fill = 0; pfx_start = 0; pfx_len = 0;
		clip_cnt = 0; timer = 0;
		cap = ring_capacity();
	endtask

	task automatic take_sample(input logic signed [15:0] s, input bit last);
		int mag;
		longint pct;
		mag = (s < 0) ? -int'(s) : int'(s);
		if (!armed && !recording) return;
		chunk_sum += mag;
		chunk_len++;
		if (chunk_len >= CHUNK_D) last = 1;
		if (armed && !recording) begin
			if (wr_pos >= cap) wr_pos = 0;
			ring_mem[wr_pos] = s;
			wr_pos = (wr_pos + 1 >= cap) ? 0 : wr_pos + 1;
			if (fill < cap) fill++;
		end
		if (recording && clip_cnt < clip_limit()) begin
			clip_mem[clip_cnt] = s;
			clip_cnt++;
		end
		if (last) begin
			pct = ((chunk_sum / chunk_len) * 100) / 32768;
			level = (pct > 100) ? PCT_MAX : pct[6:0];
			chunk_sum = 0; chunk_len = 0;
			if (recording && clip_cnt >= clip_limit()) begin
				recording = 0;
				armed = 0;
				stop = STOP_MAX;
				clip_held = clip_cnt > 0;
			end
		end
	endtask

	task automatic advance_recorder(input in_item_t it, output out_item_t r);
		int unsigned a, lim;
		r = '0;
		case (it.req_type)
			REQ_SAMPLE: take_sample(it.pcm_sample, it.chunk_end);
			REQ_ARM: begin
				armed = 1; recording = 0; preview = 0;
				stop = STOP_NONE; level = 0;
				chunk_sum = 0; chunk_len = 0;
				cap = ring_capacity();
				wr_pos = 0; fill = 0; pfx_start = 0; pfx_len = 0;
				clip_cnt = 0; clip_held = 0;
				timer = reg_delay; timer_on = 1;
			end
			REQ_START: begin
				if (!armed || recording) r.status = 1'b1;
				else begin
					pfx_len = 0;
					if (it.with_preroll) begin
						lim = clip_limit();
						if (wr_pos >= cap) wr_pos = 0;
						pfx_start = (wr_pos + cap - fill) % cap;
						pfx_len = (fill < lim) ? fill : lim;
					end
					clip_cnt = pfx_len;
					recording = 1; preview = 0; stop = STOP_NONE; timer_on = 0;
				end
			end
			REQ_FINISH: begin
				if (!armed && !recording) r.status = 1'b1;
				else begin
					if (recording) clip_held = clip_cnt > 0;
					recording = 0; armed = 0; preview = 0;
					stop = STOP_FINISH; timer_on = 0;
					chunk_sum = 0; chunk_len = 0;
				end
			end
			REQ_CANCEL: begin
				armed = 0; recording = 0; preview = 0; stop = STOP_CANCEL;
				wr_pos = 0; fill = 0; pfx_start = 0; pfx_len = 0;
				clip_cnt = 0; clip_held = 0; timer_on = 0;
				chunk_sum = 0; chunk_len = 0;
			end
			REQ_DISCARD: begin
				clip_held = 0; preview = 0;
				if (!armed && !recording) stop = STOP_NONE;
				timer_on = 0;
			end
			REQ_TICK: begin
				if (timer_on) begin
					if (timer <= 1) begin
						timer_on = 0; timer = 0;
						if (armed && !recording) preview = 1;
					end else timer--;
				end
			end
			default: begin
				if (clip_held && it.read_index < clip_cnt) begin
					if (it.read_index < pfx_len) begin
						a = pfx_start + it.read_index;
						if (a >= cap) a -= cap;
						r.read_sample = ring_mem[a];
					end else r.read_sample = clip_mem[it.read_index];
					r.read_valid = 1'b1;
				end
			end
		endcase
		r.mode_state = recording ? MODE_REC : armed ? MODE_ARMED :
			clip_held ? MODE_CLIP : MODE_IDLE;
		r.preview_on = preview;
		r.clip_present = clip_held;
		r.recorded_count = 19'(clip_cnt);
		r.level_percent = level;
		r.stop_cause = stop;
	endtask

	task automatic check_field(input string name, input longint exp, input longint act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e, g;
		if (!arst_n) begin
			reset_recorder();
			outstanding.delete();
			errors = 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PREROLL: reg_preroll = cfg_data[14:0];
					CFG_MAXCLIP: reg_maxclip = cfg_data;
					CFG_DELAY:   reg_delay = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_recorder(in_item, e);
				outstanding = {outstanding, e};
			end
			if (out_valid && !out_stall) begin
				g = out_item;
				results_seen <= results_seen + 1;
				if (outstanding.size() == 0) begin
					$error("result item with none outstanding");
					errors++;
				end else begin
					e = outstanding.pop_front();
					check_field("status", e.status, g.status);
					check_field("mode_state", e.mode_state, g.mode_state);
					check_field("preview_on", e.preview_on, g.preview_on);
					check_field("clip_present", e.clip_present, g.clip_present);
					check_field("recorded_count", e.recorded_count, g.recorded_count);
					check_field("level_percent", e.level_percent, g.level_percent);
					check_field("stop_cause", e.stop_cause, g.stop_cause);
					check_field("read_sample", e.read_sample, g.read_sample);
					check_field("read_valid", e.read_valid, g.read_valid);
				end
			end
			pending <= outstanding.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the pretrigger audio capture controller
// Drives a short directed sequence and then randomised recording sessions
// (arm, preroll, start, record, finish/cancel/discard, reads) plus random
// noise requests under several register settings and idling patterns; the
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
	import pac_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 0;
	logic                 in_stall;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 0;
	out_item_t            out_item;

	int errors, pending, results_seen;
	int items_sent = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int unsigned cap_now, lim_now;

	pretrigger_audio_capture_controller u_top (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item
	);

	pac_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item,
		.errors, .pending, .results_seen
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pretrigger_audio_capture_controller: mismatch");
			$finish;
		end
	end

	// long hold of the output side, counted here
	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			out_stall <= 1;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= 300) hold_done <= 1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_req(input req_t r, input logic [15:0] s = 0, input bit ce = 0,
			input bit pre = 0, input logic [17:0] idx = 0);
		in_item_t it;
		it.req_type = r;
		it.pcm_sample = s;
		it.chunk_end = ce;
		it.with_preroll = pre;
		it.read_index = idx;
		send_item(it);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_regs(input int unsigned pre, input int unsigned mx, input int unsigned dly);
		drain();
		write_reg(CFG_PREROLL, CFG_W'(pre));
		write_reg(CFG_MAXCLIP, CFG_W'(mx));
		write_reg(CFG_DELAY, CFG_W'(dly));
		cap_now = (pre == 0) ? 1 : (pre > 16384) ? 16384 : pre;
		lim_now = (mx > 262144) ? 262144 : mx;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_samples(input int n);
		for (int i = 0; i < n; i++)
			send_req(REQ_SAMPLE, pick_sample(), $urandom_range(5) == 0);
	endtask

	task automatic send_reads(input int n, input int unsigned span);
		for (int i = 0; i < n; i++)
			send_req(REQ_READ, 0, 0, 0, 18'($urandom_range(span + 2)));
	endtask

	task automatic session();
		int unsigned pre_n, rec_n;
		pre_n = $urandom_range(cap_now + 3 < 40 ? cap_now + 3 : 40);
		rec_n = $urandom_range(lim_now + 4 < 50 ? lim_now + 4 : 50);
		send_req(REQ_ARM);
		for (int i = $urandom_range(6); i > 0; i--) send_req(REQ_TICK);
		send_samples(pre_n);
		if ($urandom_range(9) == 0) send_req(REQ_DISCARD);
		send_req(REQ_START, 0, 0, 1'($urandom_range(1)));
		if ($urandom_range(7) == 0) send_req(REQ_START, 0, 0, 1);
		send_samples(rec_n);
		case ($urandom_range(9))
			0: send_req(REQ_CANCEL);
			1: send_req(REQ_DISCARD);
			default: send_req(REQ_FINISH);
		endcase
		send_reads($urandom_range(1, 6), pre_n + rec_n);
		if ($urandom_range(3) == 0) send_req(REQ_DISCARD);
	endtask

	task automatic noise();
		in_item_t it;
		it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
		send_item(it);
	endtask

	task automatic random_phase(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(99) < 85) session();
			else noise();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		cap_now = 16000;
		lim_now = 160000;
		@(posedge clk);

		send_idle_pct = 7;
		recv_stall_pct = 71;

		// directed
		send_req(REQ_READ);
		send_req(REQ_START, 0, 0, 1);
		send_req(REQ_FINISH);
		send_req(REQ_TICK);
		send_req(REQ_SAMPLE, 16'h7FFF, 1);
		send_req(REQ_ARM);
		send_req(REQ_FINISH);
		send_req(REQ_ARM);
		send_req(REQ_TICK);
		send_req(REQ_SAMPLE, 16'h7FFF);
		send_req(REQ_SAMPLE, 16'h8000, 1);
		send_req(REQ_SAMPLE, 16'h0000);
		send_req(REQ_START, 0, 0, 1);
		send_req(REQ_START, 0, 0, 0);
		send_req(REQ_SAMPLE, 16'hFFFF, 1);
		send_req(REQ_FINISH);
		send_req(REQ_READ, 0, 0, 0, 0);
		send_req(REQ_READ, 0, 0, 0, 3);
		send_req(REQ_READ, 0, 0, 0, 4);
		send_req(REQ_READ, 0, 0, 0, 18'h3FFFF);
		send_req(REQ_DISCARD);
		send_req(REQ_READ, 0, 0, 0, 1);
		send_req(REQ_SAMPLE, 16'h1234, 1);
		send_req(REQ_ARM);
		send_req(REQ_CANCEL);

		set_regs($urandom_range(1, 24), $urandom_range(1, 48), $urandom_range(0, 4));
		random_phase(120);
		set_regs(0, 0, 0);
		random_phase(80);
		set_regs(1, 1, 1);
		random_phase(60);

		send_idle_pct = 71;
		recv_stall_pct = 7;
		set_regs(32767, 19'h7FFFF, 65535);
		send_req(REQ_ARM);
		for (int i = 0; i < 250; i++) send_req(REQ_SAMPLE, pick_sample());
		send_req(REQ_START, 0, 0, 1);
		send_reads(8, 250);
		send_req(REQ_READ, 0, 0, 0, 249);
		send_req(REQ_FINISH);
		random_phase(40);
		set_regs(16384, 262144, 0);
		random_phase(60);
		drain();
		random_phase(60);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_regs($urandom_range(1, 40), $urandom_range(1, 60), $urandom_range(0, 3));
		hold_request = 1;
		random_phase(120);

		drain();
		repeat (60) @(posedge clk);
		$display("run covered %0d request items and %0d result items", items_sent,
			results_seen);
		$display("settings: defaults, small, zero, unit and maximum register values");
		if (errors == 0 && pending == 0)
			$display("pretrigger_audio_capture_controller: match");
		else
			$display("pretrigger_audio_capture_controller: mismatch");
		$finish;
	end

endmodule

// ----- pretrigger_audio_capture_controller.f -----
design/pac_pkg.sv
design/pac_ram.sv
design/pac_ctrl.sv
design/pac_dp.sv
design/pretrigger_audio_capture_controller.sv
test/pac_checker.sv
test/tb.sv
